>>> hw/rtl/image_header_dimension_parser_defines.svh
// Assertion macros for the image header parser checker
`ifndef IMAGE_HEADER_DIMENSION_PARSER_DEFINES_SVH
`define IMAGE_HEADER_DIMENSION_PARSER_DEFINES_SVH

// same-cycle implication
`define IHDP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IHDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ihdp_pkg.sv
`default_nettype none

package ihdp_pkg;

    localparam int unsigned HeaderBytes = 24;
    localparam int unsigned SeenW       = 5;
    localparam int unsigned FieldW      = 3;

    localparam logic [7:0] PngSig0   = 8'h89;
    localparam logic [7:0] PngSig1   = 8'h50;
    localparam logic [7:0] PngSig2   = 8'h4E;
    localparam logic [7:0] PngSig3   = 8'h47;
    localparam logic [7:0] MarkerPfx = 8'hFF;
    localparam logic [7:0] SoiCode   = 8'hD8;
    localparam logic [7:0] SofLow    = 8'hC0;
    localparam logic [7:0] SofHigh   = 8'hCF;
    localparam logic [7:0] DhtCode   = 8'hC4;
    localparam logic [7:0] JpgCode   = 8'hC8;
    localparam logic [7:0] DacCode   = 8'hCC;

    typedef enum logic [1:0] {
        FMT_PNG     = 2'd0,
        FMT_JPEG    = 2'd1,
        FMT_UNKNOWN = 2'd2
    } img_fmt_t;

    typedef enum logic [9:0] {
        PH_START    = 10'b00_0000_0001,
        PH_PNG_SIG  = 10'b00_0000_0010,
        PH_PNG_BODY = 10'b00_0000_0100,
        PH_JPG_SOI  = 10'b00_0000_1000,
        PH_MARK0    = 10'b00_0001_0000,
        PH_MARK1    = 10'b00_0010_0000,
        PH_SOF      = 10'b00_0100_0000,
        PH_SEGLEN   = 10'b00_1000_0000,
        PH_SKIP     = 10'b01_0000_0000,
        PH_DONE     = 10'b10_0000_0000
    } phase_t;

    typedef enum logic [2:0] {
        OC_NONE    = 3'd0,
        OC_PNG_OK  = 3'd1,
        OC_PNG_BAD = 3'd2,
        OC_JPG_OK  = 3'd3,
        OC_JPG_BAD = 3'd4,
        OC_UNKNOWN = 3'd5
    } outcome_t;

    function automatic img_fmt_t outcome_format(input outcome_t oc);
        img_fmt_t f;
        f = FMT_UNKNOWN;
        if (oc == OC_PNG_OK || oc == OC_PNG_BAD) f = FMT_PNG;
        else if (oc == OC_JPG_OK || oc == OC_JPG_BAD) f = FMT_JPEG;
        return f;
    endfunction

    function automatic logic is_sof(input logic [7:0] m);
        return (m >= SofLow) && (m <= SofHigh) && (m != DhtCode) && (m != JpgCode)
            && (m != DacCode);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/image_header_dimension_parser.sv
`default_nettype none

// Image header dimension parser. Takes an image file one byte per beat, last_byte
// marking the final byte, and returns one beat per file with format (PNG, JPEG or
// unrecognized), an ok flag, width and height. One byte is taken every cycle that
// in_ready is high: the parse state machine and counters update in the same cycle
// the byte is accepted; the result appears in the output register the following
// cycle. in_ready drops only while a result sits in the output register and
// out_ready is low. The result is sent once the header is decided and 24 bytes
// have arrived, or at the final byte; later bytes of the same file are dropped,
// and the final byte rearms the parser for the next file.
module image_header_dimension_parser
    import ihdp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       image_format,
    output logic             found_ok,
    output logic [31:0]      image_width,
    output logic [31:0]      image_height
);

    phase_t              phase_reg, phase_next;
    outcome_t            pend_reg, pend_next;
    logic [SeenW-1:0]    seen_reg, seen_next;
    logic [FieldW-1:0]   field_reg, field_next;
    logic [15:0]         skip_reg, skip_next;
    logic [31:0]         width_reg, width_next;
    logic [31:0]         height_reg, height_next;
    logic                sent_reg, sent_next;

    logic                out_valid_reg, out_valid_next;
    img_fmt_t            fmt_reg, fmt_next;
    logic                ok_reg, ok_next;
    logic [31:0]         ow_reg, ow_next;
    logic [31:0]         oh_reg, oh_next;

    logic                in_fire;
    logic [7:0]          png_want;
    logic [15:0]         seg_len;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        phase_next  = phase_reg;
        pend_next   = pend_reg;
        seen_next   = seen_reg;
        field_next  = field_reg;
        skip_next   = skip_reg;
        width_next  = width_reg;
        height_next = height_reg;
        sent_next   = sent_reg;

        out_valid_next = out_valid_reg && !out_ready;
        fmt_next       = fmt_reg;
        ok_next        = ok_reg;
        ow_next        = ow_reg;
        oh_next        = oh_reg;

        png_want = (seen_reg[1:0] == 2'd1) ? PngSig1 :
                   (seen_reg[1:0] == 2'd2) ? PngSig2 : PngSig3;
        seg_len  = {skip_reg[7:0], data_byte};

        if (in_fire)
        begin
            if (!sent_reg)
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (data_byte == PngSig0) phase_next = PH_PNG_SIG;
                        else if (data_byte == MarkerPfx) phase_next = PH_JPG_SOI;
                        else
                        begin
                            pend_next  = OC_UNKNOWN;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_PNG_SIG:
                    begin
                        if (data_byte != png_want)
                        begin
                            pend_next  = OC_UNKNOWN;
                            phase_next = PH_DONE;
                        end
                        else if (seen_reg >= SeenW'(3))
                        begin
                            phase_next = PH_PNG_BODY;
                        end
                    end
                    PH_PNG_BODY:
                    begin
                        if (seen_reg >= SeenW'(16) && seen_reg <= SeenW'(19))
                            width_next = {width_reg[23:0], data_byte};
                        else if (seen_reg >= SeenW'(20) && seen_reg <= SeenW'(23))
                            height_next = {height_reg[23:0], data_byte};
                        if (seen_reg >= SeenW'(23))
                        begin
                            phase_next = PH_DONE;
                            if (width_next != '0 && height_next != '0 && !width_next[31]
                                && !height_next[31])
                                pend_next = OC_PNG_OK;
                            else
                                pend_next = OC_PNG_BAD;
                        end
                    end
                    PH_JPG_SOI:
                    begin
                        if (data_byte == SoiCode) phase_next = PH_MARK0;
                        else
                        begin
                            pend_next  = OC_UNKNOWN;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_MARK0:
                    begin
                        if (data_byte == MarkerPfx) phase_next = PH_MARK1;
                        else
                        begin
                            pend_next  = OC_JPG_BAD;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_MARK1:
                    begin
                        field_next = '0;
                        skip_next  = '0;
                        phase_next = is_sof(data_byte) ? PH_SOF : PH_SEGLEN;
                    end
                    PH_SOF:
                    begin
                        if (field_reg == FieldW'(3) || field_reg == FieldW'(4))
                            height_next = {16'h0000, height_reg[7:0], data_byte};
                        else if (field_reg == FieldW'(5) || field_reg == FieldW'(6))
                            width_next = {16'h0000, width_reg[7:0], data_byte};
                        if (field_reg >= FieldW'(6))
                        begin
                            phase_next = PH_DONE;
                            pend_next  = (width_next != '0 && height_next != '0) ?
                                         OC_JPG_OK : OC_JPG_BAD;
                        end
                        else
                        begin
                            field_next = field_reg + FieldW'(1);
                        end
                    end
                    PH_SEGLEN:
                    begin
                        skip_next = seg_len;
                        if (field_reg == '0)
                        begin
                            field_next = FieldW'(1);
                        end
                        else if (seg_len < 16'd2)
                        begin
                            pend_next  = OC_JPG_BAD;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            skip_next  = seg_len - 16'd2;
                            phase_next = (seg_len == 16'd2) ? PH_MARK0 : PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_reg - 16'd1;
                        if (skip_reg == 16'd1) phase_next = PH_MARK0;
                    end
                    PH_DONE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase

                if (seen_reg < SeenW'(HeaderBytes)) seen_next = seen_reg + SeenW'(1);

                if (pend_next != OC_NONE && seen_next >= SeenW'(HeaderBytes))
                begin
                    out_valid_next = 1'b1;
                    fmt_next       = outcome_format(pend_next);
                    ok_next        = (pend_next == OC_PNG_OK) || (pend_next == OC_JPG_OK);
                    ow_next        = width_next;
                    oh_next        = height_next;
                    sent_next      = 1'b1;
                end
                else if (last_byte)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = 1'b0;
                    ow_next        = '0;
                    oh_next        = '0;
                    if (pend_next != OC_NONE)
                        fmt_next = outcome_format(pend_next);
                    else if (phase_next == PH_PNG_BODY)
                        fmt_next = FMT_PNG;
                    else if (phase_next == PH_MARK0 || phase_next == PH_MARK1
                             || phase_next == PH_SOF || phase_next == PH_SEGLEN
                             || phase_next == PH_SKIP)
                        fmt_next = FMT_JPEG;
                    else
                        fmt_next = FMT_UNKNOWN;
                end
            end

            if (last_byte)
            begin
                phase_next  = PH_START;
                pend_next   = OC_NONE;
                seen_next   = '0;
                field_next  = '0;
                skip_next   = '0;
                width_next  = '0;
                height_next = '0;
                sent_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            pend_reg      <= OC_NONE;
            seen_reg      <= '0;
            field_reg     <= '0;
            skip_reg      <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            sent_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pend_reg      <= pend_next;
            seen_reg      <= seen_next;
            field_reg     <= field_next;
            skip_reg      <= skip_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fmt_reg <= fmt_next;
        ok_reg  <= ok_next;
        ow_reg  <= ow_next;
        oh_reg  <= oh_next;
    end

    assign out_valid    = out_valid_reg;
    assign image_format = fmt_reg;
    assign found_ok     = ok_reg;
    assign image_width  = ow_reg;
    assign image_height = oh_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ihdp_checker.sv
`default_nettype none

`include "image_header_dimension_parser_defines.svh"

module ihdp_checker
    import ihdp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  data_byte,
    input wire logic        last_byte,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  image_format,
    input wire logic        found_ok,
    input wire logic [31:0] image_width,
    input wire logic [31:0] image_height
);

    `IHDP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(image_width) && $stable(image_height) && $stable(found_ok),
        "result beat changed while stalled")

    `IHDP_ASSERT_NOW(a_ok_dims, out_valid && found_ok,
        image_width != 32'd0 && image_height != 32'd0 && image_format != FMT_UNKNOWN,
        "ok result with zero dimension or unknown format")

    `IHDP_ASSERT_NOW(a_unknown_zero, out_valid && image_format == FMT_UNKNOWN,
        !found_ok && image_width == 32'd0 && image_height == 32'd0,
        "unrecognized file reported dimensions")

    `IHDP_ASSERT_NOW(a_jpeg_16bit, out_valid && image_format == FMT_JPEG,
        image_width[31:16] == 16'd0 && image_height[31:16] == 16'd0,
        "jpeg dimension wider than 16 bits")

    `IHDP_ASSERT_NOW(a_png_ok_range, out_valid && found_ok && image_format == FMT_PNG,
        !image_width[31] && !image_height[31],
        "png ok with top bit set")

endmodule

bind image_header_dimension_parser ihdp_checker u_ihdp_checker (.*);

`default_nettype wire
